### hdl/ufd_pkg.sv
// shared constants and control/status types for the uart frame deframer
package ufd_pkg;

   localparam logic [7:0] HDR0          = 8'h5A;
   localparam logic [7:0] HDR1          = 8'hA5;
   localparam logic [7:0] MAX_RUN_BYTES = 8'd128;
   localparam logic [7:0] CHUNK_BYTES   = 8'd8;
   localparam int         VALUE_OFFSET  = 6;

   // datapath to controller
   typedef struct packed {
      logic full;       // store already holds a whole buffer
      logic cnt_is1;    // incoming byte is the second header byte
      logic cnt_is3;    // incoming byte is the low length byte
      logic hdr_ok;     // both header bytes match
      logic len_short;  // declared length below three
      logic frame_end;  // incoming byte is the checksum byte
      logic sum_ok;     // checksum byte matches running xor
      logic run_last;   // current chunk is the last of the run
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic store;       // take the incoming byte
      logic clear;       // drop the frame in progress
      logic load_len;    // latch the 16-bit length
      logic start_run;   // set up the output run
      logic read_row;    // fetch one chunk row from the store
      logic next_chunk;  // advance to the next chunk
   } command_type;

endpackage

### hdl/ufd_if.sv
// handshake channels for received bytes and frame results
interface ufd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ufd_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  command_code;
   logic [7:0]  value_length;
   logic [63:0] chunk_data;
   logic [3:0]  chunk_bytes;
   logic        last;

   modport source (output valid, output command_code, output value_length,
                   output chunk_data, output chunk_bytes, output last, input ready);
   modport sink   (input valid, input command_code, input value_length,
                   input chunk_data, input chunk_bytes, input last, output ready);
endinterface

### hdl/ufd_datapath.sv
// byte counter, running xor, frame fields, chunk store and result payload
module ufd_datapath #(
   parameter int BUFFER_BYTES = 128
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [7:0]           rx_byte,
   input  ufd_pkg::command_type cmd,
   output ufd_pkg::status_type  status,
   output logic [7:0]           command_code,
   output logic [7:0]           value_length,
   output logic [63:0]          chunk_data,
   output logic [3:0]           chunk_bytes,
   output logic                 last
);

   localparam int CW   = $clog2(BUFFER_BYTES + 1);
   localparam int ROWS = (BUFFER_BYTES - ufd_pkg::VALUE_OFFSET + 7) / 8;
   localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;

   logic [CW-1:0] count_ff, count_in;
   logic [7:0]    xor_ff, xor_in;
   logic [7:0]    hdr0_ff, len_hi_ff, cmd_ff, vlen_ff;
   logic [15:0]   len_ff;
   logic [7:0]    rem_ff;
   logic [RW-1:0] row_ff;
   logic [63:0]   rdata_ff;
   logic [63:0]   mem_ff [ROWS];

   logic [CW-1:0] widx;
   logic [RW-1:0] wrow;
   logic [2:0]    wlane;
   logic          wen;
   logic [15:0]   len_new;
   logic [15:0]   lm3;
   logic [7:0]    nv;
   logic [7:0]    n_run;
   logic [3:0]    m;

   assign widx    = count_ff - CW'(ufd_pkg::VALUE_OFFSET);
   assign wrow    = RW'(widx >> 3);
   assign wlane   = widx[2:0];
   assign wen     = cmd.store && (count_ff >= CW'(ufd_pkg::VALUE_OFFSET));
   assign len_new = {len_hi_ff, rx_byte};

   // value byte count of the run: min(length - 3, declared, 128)
   assign lm3   = len_ff - 16'd3;
   assign nv    = (lm3 < {8'd0, vlen_ff}) ? lm3[7:0] : vlen_ff;
   assign n_run = (nv > ufd_pkg::MAX_RUN_BYTES) ? ufd_pkg::MAX_RUN_BYTES : nv;

   always_comb begin
      status.full      = (count_ff == CW'(BUFFER_BYTES));
      status.cnt_is1   = (count_ff == CW'(1));
      status.cnt_is3   = (count_ff == CW'(3));
      status.hdr_ok    = (hdr0_ff == ufd_pkg::HDR0) && (rx_byte == ufd_pkg::HDR1);
      status.len_short = (len_new < 16'd3);
      status.frame_end = (17'(count_ff) == (17'(len_ff) + 17'd3));
      status.sum_ok    = (xor_ff == rx_byte);
      status.run_last  = (rem_ff <= ufd_pkg::CHUNK_BYTES);
   end

   always_comb begin
      count_in = count_ff;
      xor_in   = xor_ff;
      if (cmd.clear) begin
         count_in = '0;
         xor_in   = 8'd0;
      end else if (cmd.store) begin
         count_in = count_ff + CW'(1);
         xor_in   = xor_ff ^ rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         xor_ff   <= 8'd0;
      end else begin
         count_ff <= count_in;
         xor_ff   <= xor_in;
      end
   end

   // frame fields by byte position
   always_ff @(posedge clock) begin
      if (cmd.store) begin
         if (count_ff == CW'(0)) hdr0_ff   <= rx_byte;
         if (count_ff == CW'(2)) len_hi_ff <= rx_byte;
         if (count_ff == CW'(4)) cmd_ff    <= rx_byte;
         if (count_ff == CW'(5)) vlen_ff   <= rx_byte;
      end
      if (cmd.load_len) begin
         len_ff <= len_new;
      end
   end

   // run bookkeeping
   always_ff @(posedge clock) begin
      if (cmd.start_run) begin
         rem_ff <= n_run;
         row_ff <= '0;
      end else if (cmd.next_chunk) begin
         rem_ff <= rem_ff - ufd_pkg::CHUNK_BYTES;
         row_ff <= row_ff + RW'(1);
      end
   end

   // chunk store, value bytes laid out eight to a row
   always_ff @(posedge clock) begin
      if (wen) begin
         mem_ff[wrow][8*wlane +: 8] <= rx_byte;
      end
      if (cmd.read_row) begin
         rdata_ff <= mem_ff[row_ff];
      end
   end

   assign m = (rem_ff > ufd_pkg::CHUNK_BYTES) ? 4'd8 : rem_ff[3:0];

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         chunk_data[8*i +: 8] = (4'(i) < m) ? rdata_ff[8*i +: 8] : 8'd0;
      end
   end

   assign command_code = cmd_ff;
   assign value_length = vlen_ff;
   assign chunk_bytes  = m;
   assign last         = status.run_last;

endmodule

### hdl/ufd_controller.sv
// parse and run sequencing state machine
module ufd_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  ufd_pkg::status_type  status,
   output ufd_pkg::command_type cmd
);

   localparam logic [2:0] ST_HDR  = 3'd0;
   localparam logic [2:0] ST_LEN  = 3'd1;
   localparam logic [2:0] ST_DATA = 3'd2;
   localparam logic [2:0] ST_READ = 3'd3;
   localparam logic [2:0] ST_SEND = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       acc;

   assign acc = req_valid && req_ready;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff) inside
         ST_HDR, ST_LEN, ST_DATA: begin
            req_ready = 1'b1;
            if (acc) begin
               if (status.full) begin
                  cmd.clear = 1'b1;
                  state_in  = ST_HDR;
               end else begin
                  cmd.store = 1'b1;
                  if (state_ff == ST_HDR) begin
                     if (status.cnt_is1) begin
                        if (status.hdr_ok) state_in = ST_LEN;
                        else cmd.clear = 1'b1;
                     end
                  end else if (state_ff == ST_LEN) begin
                     if (status.cnt_is3) begin
                        cmd.load_len = 1'b1;
                        if (status.len_short) begin
                           cmd.clear = 1'b1;
                           state_in  = ST_HDR;
                        end else begin
                           state_in = ST_DATA;
                        end
                     end
                  end else if (status.frame_end) begin
                     cmd.clear = 1'b1;
                     if (status.sum_ok) begin
                        cmd.start_run = 1'b1;
                        state_in      = ST_READ;
                     end else begin
                        state_in = ST_HDR;
                     end
                  end
               end
            end
         end
         ST_READ: begin
            cmd.read_row = 1'b1;
            state_in     = ST_SEND;
         end
         ST_SEND: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (status.run_last) begin
                  state_in = ST_HDR;
               end else begin
                  cmd.next_chunk = 1'b1;
                  state_in       = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_HDR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HDR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hdl/uart_frame_deframer_xor.sv
// top level: uart frame deframer with xor checksum
// parsing: one received item per cycle; the first result is valid after the checksum
//   item is taken and one store row is read (read state, then send state)
// results: each result is a store row read followed by a send state that waits for
//   ready, so output stalls hold the run; a frame's run holds 1 to 16 results
// reset: synchronous, active high; parser returns to header search, store is not cleared
module uart_frame_deframer_xor #(
   parameter int BUFFER_BYTES = 128
) (
   input logic     clock,
   input logic     reset,
   ufd_req_if.sink req_chan,
   ufd_rsp_if.source rsp_chan
);

   // command and status between the sequencer and the datapath
   ufd_pkg::command_type cmd;
   ufd_pkg::status_type  status;

   // sequencer: header, length and data phases, then the chunk run
   // input is held off (ready low) for the whole run
   ufd_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: byte count, running xor, frame fields, value byte store
   // value bytes land in rows of eight so one read returns a whole chunk
   ufd_datapath #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .rx_byte      (req_chan.rx_byte),
      .cmd          (cmd),
      .status       (status),
      .command_code (rsp_chan.command_code),
      .value_length (rsp_chan.value_length),
      .chunk_data   (rsp_chan.chunk_data),
      .chunk_bytes  (rsp_chan.chunk_bytes),
      .last         (rsp_chan.last)
   );

   // no item is taken while a result is shown
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !req_chan.ready)
      else $error("input taken during result run");

   // parser resumes right after the last result of a run
   a_resume: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && rsp_chan.last) |=> req_chan.ready)
      else $error("parser did not resume after run");

   // every result but the last carries a full chunk
   a_full_chunk: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.last) |-> (rsp_chan.chunk_bytes == 4'd8))
      else $error("short chunk before end of run");

   // chunk byte count never exceeds eight
   a_chunk_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.chunk_bytes <= 4'd8))
      else $error("chunk byte count out of range");

endmodule

### sim/tb_uart_frame_deframer_xor.sv
// self-checking testbench for the uart frame deframer with xor checksum
module tb_uart_frame_deframer_xor;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int BUFFER_BYTES = 128;
   localparam int LONG_HOLD    = 300;        // receiver hold-off, in cycles
   localparam int TIMEOUT_NS   = 5_000_000;  // far above the slowest correct run
   localparam int DRAIN_CYCLES = 40;         // room for the store row read and a 16-result run

   // one result item as the block should present it
   typedef struct {
      logic [7:0]  command_code;
      logic [7:0]  value_length;
      logic [63:0] chunk_data;
      logic [3:0]  chunk_bytes;
      logic        last;
   } frame_chunk_type;

   // parser position in the frame, mirrored from the block's behavior
   typedef enum logic [1:0] {SEEK_HEADER, READ_LENGTH, READ_BODY} parse_state_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ufd_req_if req_chan ();
   ufd_rsp_if rsp_chan ();

   uart_frame_deframer_xor #(.BUFFER_BYTES(BUFFER_BYTES)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #5 clock = ~clock;

   // bytes waiting to be offered, and result items still owed by the block
   logic [7:0]      byte_backlog [$];
   frame_chunk_type chunks_due [$];
   frame_chunk_type chunk_seen;

   // predictor state
   parse_state_type parse_state = SEEK_HEADER;
   logic [7:0]      frame_bytes [BUFFER_BYTES];
   int unsigned     stored = 0;
   logic [15:0]     declared_len = '0;

   // idling knobs, changed only at the falling edge
   int  send_idle_pct  = 0;
   int  recv_stall_pct = 0;
   logic rsp_hold = 1'b0;
   event hold_kick;

   int unsigned items_queued   = 0;
   int unsigned items_accepted = 0;
   int unsigned results_checked = 0;
   int unsigned good_frames    = 0;
   int unsigned dropped_frames = 0;
   int unsigned error_count    = 0;

   // ---------------------------------------------------------------------
   // mismatch reporting: one line each, and a count
   // ---------------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      $display("%0t ERROR: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic compare_field(input string name, input logic [63:0] got,
                                input logic [63:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d: %s got %h want %h",
                                   results_checked, name, got, want));
   endtask

   // ---------------------------------------------------------------------
   // predictor: consumes one accepted byte, queues the chunks it releases
   // ---------------------------------------------------------------------
   task automatic deframe_byte(input logic [7:0] rx);
      logic [7:0]      running_xor;
      int unsigned     n_value, n_chunks, m, frame_end;
      frame_chunk_type c;

      // store already full: the byte is lost and the frame with it
      if (stored >= BUFFER_BYTES) begin
         stored      = 0;
         parse_state = SEEK_HEADER;
         dropped_frames++;
         return;
      end
      frame_bytes[stored] = rx;
      stored++;

      case (parse_state)
         SEEK_HEADER: begin
            // header judged in pairs, no sliding search
            if (stored >= 2) begin
               if (frame_bytes[0] != ufd_pkg::HDR0 || frame_bytes[1] != ufd_pkg::HDR1) begin
                  stored = 0;
                  dropped_frames++;
               end else begin
                  parse_state = READ_LENGTH;
               end
            end
         end
         READ_LENGTH: begin
            if (stored >= 4) begin
               declared_len = {frame_bytes[2], frame_bytes[3]};
               if (declared_len < 3) begin
                  stored      = 0;
                  parse_state = SEEK_HEADER;
                  dropped_frames++;
               end else begin
                  parse_state = READ_BODY;
               end
            end
         end
         default: begin
            if (stored == declared_len + 4) begin
               running_xor = '0;
               for (int i = 0; i + 1 < stored; i++)
                  running_xor ^= frame_bytes[i];
               frame_end   = stored;
               stored      = 0;
               parse_state = SEEK_HEADER;
               if (running_xor != frame_bytes[frame_end - 1]) begin
                  dropped_frames++;
                  return;
               end
               good_frames++;
               // value bytes: the fewer of declared and present, capped per run
               n_value = declared_len - 3;
               if (frame_bytes[5] < n_value)
                  n_value = 32'(frame_bytes[5]);
               if (n_value > ufd_pkg::MAX_RUN_BYTES)
                  n_value = 32'(ufd_pkg::MAX_RUN_BYTES);
               n_chunks = (n_value + ufd_pkg::CHUNK_BYTES - 1) / ufd_pkg::CHUNK_BYTES;
               if (n_chunks == 0)
                  n_chunks = 1;   // empty value still gives one closing item
               for (int k = 0; k < n_chunks; k++) begin
                  if (n_value > k * ufd_pkg::CHUNK_BYTES)
                     m = (n_value - k * ufd_pkg::CHUNK_BYTES < ufd_pkg::CHUNK_BYTES) ?
                         n_value - k * ufd_pkg::CHUNK_BYTES : ufd_pkg::CHUNK_BYTES;
                  else
                     m = 0;
                  c.command_code = frame_bytes[4];
                  c.value_length = frame_bytes[5];
                  c.chunk_data   = '0;
                  for (int i = 0; i < m; i++)
                     c.chunk_data[8*i +: 8] =
                        frame_bytes[ufd_pkg::VALUE_OFFSET + k * ufd_pkg::CHUNK_BYTES + i];
                  c.chunk_bytes  = m[3:0];
                  c.last         = (k + 1 == n_chunks);
                  chunks_due.push_back(c);
               end
            end
         end
      endcase
   endtask

   // ---------------------------------------------------------------------
   // stimulus builders
   // ---------------------------------------------------------------------
   task automatic push_byte(input logic [7:0] b);
      byte_backlog.push_back(b);
      items_queued++;
   endtask

   task automatic queue_header(input logic [15:0] len);
      push_byte(ufd_pkg::HDR0);
      push_byte(ufd_pkg::HDR1);
      push_byte(len[15:8]);
      push_byte(len[7:0]);
   endtask

   // whole frame with random value bytes; corrupt spoils the checksum
   task automatic queue_frame(input logic [15:0] len, input logic [7:0] cmd,
                              input logic [7:0] vlen, input bit corrupt);
      logic [7:0] running_xor;
      logic [7:0] b;
      queue_header(len);
      running_xor = ufd_pkg::HDR0 ^ ufd_pkg::HDR1 ^ len[15:8] ^ len[7:0] ^ cmd ^ vlen;
      push_byte(cmd);
      push_byte(vlen);
      for (int i = 0; i < len - 3; i++) begin
         b = 8'($urandom);
         running_xor ^= b;
         push_byte(b);
      end
      if (corrupt)
         running_xor ^= 8'($urandom_range(1, 255));
      push_byte(running_xor);
   endtask

   // declared value length: exact, zero, anything, or at most what is sent
   function automatic logic [7:0] pick_value_length(input logic [15:0] len);
      case ($urandom_range(3))
         0:       return 8'(len - 16'd3);
         1:       return 8'h00;
         2:       return 8'($urandom);
         default: return 8'($urandom_range(len - 3));
      endcase
   endfunction

   // mostly good frames of small size, some large good frames, the rest broken frames and noise
   task automatic queue_random_traffic(input int unsigned budget);
      int unsigned stop_at, pick;
      logic [15:0] len;
      logic [7:0]  b;
      stop_at = items_queued + budget;
      while (items_queued < stop_at) begin
         pick = $urandom_range(99);
         len  = 16'(3 + $urandom_range(15));
         if (pick < 60) begin
            queue_frame(len, 8'($urandom), pick_value_length(len), 1'b0);
         end else if (pick < 64) begin
            len = 16'($urandom_range(40, 124));
            queue_frame(len, 8'($urandom), pick_value_length(len), 1'b0);
         end else if (pick < 74) begin
            queue_frame(len, 8'($urandom), pick_value_length(len), 1'b1);
         end else if (pick < 82) begin
            queue_header(16'($urandom_range(2)));
         end else if (pick < 90) begin
            b = 8'($urandom);
            if ($urandom_range(1)) begin
               if (b == ufd_pkg::HDR1) b ^= 8'h01;
               push_byte(ufd_pkg::HDR0);
               push_byte(b);
            end else begin
               if (b == ufd_pkg::HDR0) b ^= 8'h01;
               push_byte(b);
               push_byte(ufd_pkg::HDR1);
            end
         end else begin
            push_byte(8'($urandom));
            push_byte(8'($urandom));
         end
      end
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   // sender pause: nothing left to offer and every result item back
   task automatic wait_quiet();
      while (byte_backlog.size() != 0 || chunks_due.size() != 0)
         @(negedge clock);
   endtask

   // ---------------------------------------------------------------------
   // driver: offers the backlog, holds an item until it is taken
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            deframe_byte(req_chan.rx_byte);
            void'(byte_backlog.pop_front());
            items_accepted++;
         end
         if (!(req_chan.valid && !req_chan.ready)) begin
            if (byte_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_chan.valid   <= 1'b1;
               req_chan.rx_byte <= byte_backlog[0];
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // monitor: checks each result item against the oldest one owed
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (chunks_due.size() == 0) begin
               report_mismatch($sformatf("unexpected result: cmd %h data %h bytes %0d",
                                         rsp_chan.command_code, rsp_chan.chunk_data,
                                         rsp_chan.chunk_bytes));
            end else begin
               chunk_seen = chunks_due.pop_front();
               compare_field("command_code", 64'(rsp_chan.command_code),
                             64'(chunk_seen.command_code));
               compare_field("value_length", 64'(rsp_chan.value_length),
                             64'(chunk_seen.value_length));
               compare_field("chunk_data", rsp_chan.chunk_data, chunk_seen.chunk_data);
               compare_field("chunk_bytes", 64'(rsp_chan.chunk_bytes),
                             64'(chunk_seen.chunk_bytes));
               compare_field("last", 64'(rsp_chan.last), 64'(chunk_seen.last));
            end
            results_checked++;
         end
         rsp_chan.ready <= !rsp_hold && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // long receiver hold-off, counted here on falling edges
   always begin
      @(hold_kick);
      rsp_hold = 1'b1;
      repeat (LONG_HOLD) @(negedge clock);
      rsp_hold = 1'b0;
   end

   // ---------------------------------------------------------------------
   // watchdog
   // ---------------------------------------------------------------------
   initial begin
      #(TIMEOUT_NS);
      $display("timeout with %0d bytes pending and %0d result items owed",
               byte_backlog.size(), chunks_due.size());
      $display("tb_uart_frame_deframer_xor: FAIL");
      $finish;
   end

   // ---------------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------------
   initial begin
      req_chan.valid   = 1'b0;
      req_chan.rx_byte = 8'h00;
      rsp_chan.ready   = 1'b0;
      set_idling(0, 0);
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: header faults, short length, empty value, bad checksum
      @(negedge clock);
      push_byte(ufd_pkg::HDR0);
      push_byte(8'h00);                       // second header byte wrong
      push_byte(8'h00);
      push_byte(ufd_pkg::HDR1);               // first header byte wrong
      queue_header(16'd2);                    // length below three
      queue_frame(16'd3, 8'h00, 8'hFF, 1'b0); // no value bytes, declared more
      queue_frame(16'd4, 8'hFF, 8'h00, 1'b1); // checksum off
      wait_quiet();

      // random traffic under each idling pattern, drained in between
      set_idling(0, 0);
      queue_random_traffic(24);
      wait_quiet();

      @(negedge clock);
      set_idling(60, 0);
      // overrun: length larger than the store, one byte past full
      queue_header(16'hFFFF);
      for (int i = 0; i < BUFFER_BYTES - 3; i++)
         push_byte(8'($urandom));
      queue_random_traffic(10);
      wait_quiet();

      @(negedge clock);
      set_idling(0, 60);
      queue_random_traffic(24);
      wait_quiet();

      @(negedge clock);
      set_idling(14, 14);
      queue_random_traffic(24);
      wait_quiet();

      // receiver goes quiet while a full-length run and another frame pile in
      @(negedge clock);
      set_idling(0, 0);
      -> hold_kick;
      queue_frame(16'd124, 8'hFF, 8'hFF, 1'b0);
      queue_frame(16'(3 + $urandom_range(15)), 8'($urandom), 8'($urandom), 1'b0);
      wait_quiet();

      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d bytes taken, %0d good frames, %0d frames dropped, %0d results",
               items_accepted, good_frames, dropped_frames, results_checked);
      $display("idling: none, sender 60%%, receiver 60%%, both 14%%, and a %0d-cycle hold",
               LONG_HOLD);
      if (error_count == 0 && chunks_due.size() == 0) begin
         $display("tb_uart_frame_deframer_xor: PASS");
      end else begin
         $display("tb_uart_frame_deframer_xor: FAIL");
      end
      $finish;
   end

endmodule
